// ===== hw/rtl/vector_line_dac_stepper_unit_assert.svh =====
// assertion macros for the line stepper
`ifndef VECTOR_LINE_DAC_STEPPER_UNIT_ASSERT_SVH
`define VECTOR_LINE_DAC_STEPPER_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define VLDS_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("line stepper check failed");

// next-cycle implication, quiet during reset
`define VLDS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("line stepper check failed");

`endif

// ===== hw/rtl/vlds_pkg.sv =====
// shared constants and control types of the line stepper
package vlds_pkg;

    localparam int SEG_FIELD_BITS     = 8;
    localparam int FRAME_BITS         = 16;
    localparam int NIBBLE_BITS        = 4;
    localparam int DAC_BITS           = 12;
    localparam int ACC_BITS           = 16;
    localparam int DEF_COORD_BITS     = 8;
    localparam int DEF_FRACTION_BITS  = 7;
    localparam int APB_DATA_BITS      = 32;
    localparam int APB_ADDR_BITS      = 3;

    localparam logic [NIBBLE_BITS-1:0] NIBBLE_RESET = 4'h3;

    // word index of the control nibble register
    localparam logic [0:0] REG_NIBBLE = 1'b0;

    typedef struct packed {
        logic load;   // capture segment coordinates
        logic setup;  // compute steps, start points and count
        logic emit;   // advance one or two points into the output register
    } cmd_t;

    typedef struct packed {
        logic short_seg;  // larger span below two
        logic last;       // this emit finishes the segment
    } status_t;

endpackage

// ===== hw/rtl/seg_if.sv =====
// segment input channel
interface seg_if
    import vlds_pkg::*;
();

    logic                      valid;
    logic                      ready;
    logic [SEG_FIELD_BITS-1:0] start_x;
    logic [SEG_FIELD_BITS-1:0] start_y;
    logic [SEG_FIELD_BITS-1:0] end_x;
    logic [SEG_FIELD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== hw/rtl/frame_if.sv =====
// dac frame output channel
interface frame_if
    import vlds_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic [FRAME_BITS-1:0] first_x_frame;
    logic [FRAME_BITS-1:0] first_y_frame;
    logic [FRAME_BITS-1:0] second_x_frame;
    logic [FRAME_BITS-1:0] second_y_frame;
    logic                  second_valid;
    logic                  last_of_segment;

    modport source (output valid, first_x_frame, first_y_frame, second_x_frame,
                    second_y_frame, second_valid, last_of_segment, input ready);
    modport sink   (input valid, first_x_frame, first_y_frame, second_x_frame,
                    second_y_frame, second_valid, last_of_segment, output ready);
endinterface

// ===== hw/rtl/vlds_ctrl.sv =====
// sequencing state machine of the line stepper
module vlds_ctrl
    import vlds_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                if (status.short_seg)
                    state_next = ST_IDLE;
                else
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/vlds_datapath.sv =====
// coordinate, step and accumulator datapath of the line stepper
module vlds_datapath
    import vlds_pkg::*;
#(
    parameter int COORD_BITS    = DEF_COORD_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                      clk,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic [NIBBLE_BITS-1:0]    nibble,
    input  logic [SEG_FIELD_BITS-1:0] start_x,
    input  logic [SEG_FIELD_BITS-1:0] start_y,
    input  logic [SEG_FIELD_BITS-1:0] end_x,
    input  logic [SEG_FIELD_BITS-1:0] end_y,
    output logic [FRAME_BITS-1:0]     first_x_frame,
    output logic [FRAME_BITS-1:0]     first_y_frame,
    output logic [FRAME_BITS-1:0]     second_x_frame,
    output logic [FRAME_BITS-1:0]     second_y_frame,
    output logic                      second_valid,
    output logic                      last_of_segment
);

    localparam int CB  = COORD_BITS;
    localparam int LGW = (CB > 2) ? $clog2(CB) : 1;
    localparam int SH  = COORD_BITS + FRACTION_BITS - DAC_BITS;
    localparam int SHR = (SH >= 0) ? SH : 0;
    localparam int SHL = (SH < 0) ? -SH : 0;

    logic [CB-1:0]       x1_reg, y1_reg, x2_reg, y2_reg;
    logic [ACC_BITS-1:0] x_acc_reg, y_acc_reg, x_step_reg, y_step_reg;
    logic [CB-1:0]       steps_reg;
    logic [1:0]          dir_reg;
    logic [FRAME_BITS-1:0] fx_reg, fy_reg, sx_reg, sy_reg;
    logic                sv_reg, last_reg;

    logic [CB-1:0]       dx, dy, span, span_m1, n_val;
    logic [LGW-1:0]      lg;
    logic [ACC_BITS-1:0] x_p1, y_p1, x_p2, y_p2;
    logic                two_pts;

    function automatic logic [FRAME_BITS-1:0] to_frame(
        input logic [NIBBLE_BITS-1:0] nib,
        input logic [ACC_BITS-1:0]    acc
    );
        logic [ACC_BITS-1:0] scaled;
        scaled   = (acc >> SHR) << SHL;
        to_frame = {nib, scaled[DAC_BITS-1:0]};
    endfunction

    function automatic logic [ACC_BITS-1:0] advance(
        input logic [ACC_BITS-1:0] acc,
        input logic [ACC_BITS-1:0] step,
        input logic                rising
    );
        advance = rising ? acc + step : acc - step;
    endfunction

    // spans and the largest power of two strictly below the larger one
    always_comb
    begin
        dx      = (x1_reg > x2_reg) ? x1_reg - x2_reg : x2_reg - x1_reg;
        dy      = (y1_reg > y2_reg) ? y1_reg - y2_reg : y2_reg - y1_reg;
        span    = (dx > dy) ? dx : dy;
        span_m1 = span - CB'(1);
        lg      = '0;
        for (int i = 0; i < CB; i++)
        begin
            if (span_m1[i])
                lg = LGW'(i);
        end
        n_val = CB'(1) << lg;
    end

    // two successive points per emit
    always_comb
    begin
        x_p1    = advance(x_acc_reg, x_step_reg, dir_reg[0]);
        y_p1    = advance(y_acc_reg, y_step_reg, dir_reg[1]);
        x_p2    = advance(x_p1, x_step_reg, dir_reg[0]);
        y_p2    = advance(y_p1, y_step_reg, dir_reg[1]);
        two_pts = (steps_reg != CB'(1));
    end

    assign status.short_seg = (span < CB'(2));
    assign status.last      = (steps_reg == CB'(1)) || (steps_reg == CB'(2));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x1_reg <= start_x[CB-1:0];
            y1_reg <= start_y[CB-1:0];
            x2_reg <= end_x[CB-1:0];
            y2_reg <= end_y[CB-1:0];
        end
        if (cmd.setup)
        begin
            x_step_reg <= (ACC_BITS'(dx) << FRACTION_BITS) >> lg;
            y_step_reg <= (ACC_BITS'(dy) << FRACTION_BITS) >> lg;
            x_acc_reg  <= ACC_BITS'(x1_reg) << FRACTION_BITS;
            y_acc_reg  <= ACC_BITS'(y1_reg) << FRACTION_BITS;
            dir_reg    <= {y1_reg < y2_reg, x1_reg < x2_reg};
            steps_reg  <= n_val;
        end
        if (cmd.emit)
        begin
            x_acc_reg <= x_p2;
            y_acc_reg <= y_p2;
            steps_reg <= two_pts ? steps_reg - CB'(2) : steps_reg - CB'(1);
            fx_reg    <= to_frame(nibble, x_p1);
            fy_reg    <= to_frame(nibble, y_p1);
            sx_reg    <= two_pts ? to_frame(nibble, x_p2) : '0;
            sy_reg    <= two_pts ? to_frame(nibble, y_p2) : '0;
            sv_reg    <= two_pts;
            last_reg  <= status.last;
        end
    end

    assign first_x_frame   = fx_reg;
    assign first_y_frame   = fy_reg;
    assign second_x_frame  = sx_reg;
    assign second_y_frame  = sy_reg;
    assign second_valid    = sv_reg;
    assign last_of_segment = last_reg;

endmodule

// ===== hw/rtl/vector_line_dac_stepper_unit.sv =====
// top level of the line stepper: config register, controller and datapath
// usage:
// - segment channel: one beat carries start_x, start_y, end_x, end_y; only the
//   low COORD_BITS bits of each coordinate are used
// - frame channel: each beat carries two dac points (x and y frames, nibble in
//   bits 15..12), second_valid when the second pair is present and
//   last_of_segment on the final beat of a segment
// - a segment whose larger span is below two gives no frame beats at all
// - timing: a taken segment beat is captured, the setup state then works out
//   step sizes, start points and point count N (largest power of two below
//   the larger span), then the run state produces one frame beat a cycle
//   while the receiver takes them; the single accumulator pair advances up to
//   two points per frame beat
// - segment ready is high only while the sequencer is idle; the next segment
//   is taken while the last frame beat still waits in the output register
// - when the receiver stalls, the output register holds its beat and the
//   accumulators wait; no point is dropped or repeated
// - apb register 0 holds the control nibble (reset 3); write it only while idle
// - reset clears the sequencer and the output valid flag and sets the nibble
`include "vector_line_dac_stepper_unit_assert.svh"

module vector_line_dac_stepper_unit
    import vlds_pkg::*;
#(
    parameter int COORD_BITS    = DEF_COORD_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    seg_if.sink                      segment,
    frame_if.source                  frame,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [NIBBLE_BITS-1:0] nibble_reg, nibble_next;
    logic                   reg_hit;
    logic                   cfg_write;
    cmd_t                   cmd;
    status_t                status;

    // configuration port: one word register, no wait states
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[APB_ADDR_BITS-1:2] == REG_NIBBLE);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        nibble_next = nibble_reg;
        if (cfg_write && reg_hit)
            nibble_next = pwdata[NIBBLE_BITS-1:0];
    end

    assign prdata = reg_hit ? APB_DATA_BITS'(nibble_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nibble_reg <= NIBBLE_RESET;
        else
            nibble_reg <= nibble_next;
    end

    // sequencer
    vlds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (segment.valid),
        .in_ready  (segment.ready),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // step generation and frame packing
    vlds_datapath #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk             (clk),
        .cmd             (cmd),
        .status          (status),
        .nibble          (nibble_reg),
        .start_x         (segment.start_x),
        .start_y         (segment.start_y),
        .end_x           (segment.end_x),
        .end_y           (segment.end_y),
        .first_x_frame   (frame.first_x_frame),
        .first_y_frame   (frame.first_y_frame),
        .second_x_frame  (frame.second_x_frame),
        .second_y_frame  (frame.second_y_frame),
        .second_valid    (frame.second_valid),
        .last_of_segment (frame.last_of_segment)
    );

    // a taken segment beat is followed by the setup cycle
    `VLDS_ASSERT_NEXT(a_setup_after_load, clk, rst_n,
        segment.valid && segment.ready, !segment.ready)
    // finishing a segment returns the sequencer to idle
    `VLDS_ASSERT_NEXT(a_idle_after_last, clk, rst_n,
        cmd.emit && status.last, segment.ready)
    // a lone point only happens for a single-step segment
    `VLDS_ASSERT_NOW(a_single_is_last, clk, rst_n,
        frame.valid && !frame.second_valid,
        frame.last_of_segment && frame.second_x_frame == '0 && frame.second_y_frame == '0)

endmodule
